// ----- hw/rtl/mvih_pkg.sv -----
package mvih_pkg;

  localparam int MUON_DEPTH_DEF     = 64;
  localparam int HIST_BINS_DEF      = 200;
  localparam int DETECTOR_COUNT_DEF = 4;

  localparam int TIME_W     = 63;
  localparam int CLS_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [31:0] CROSS_MASK = 32'h1000_0002;
  localparam int NS_PER_US = 1000;
  localparam int BIN_NS    = 10000;

  // dt / BIN_NS by reciprocal, one-step correction downward
  localparam int DT_W      = 24;
  localparam int DIV_SHIFT = 29;
  localparam int RECIP_W   = 17;
  localparam int DIV_RECIP = (2 ** DIV_SHIFT + BIN_NS - 1) / BIN_NS;
  localparam int Q_W       = DT_W + RECIP_W - DIV_SHIFT;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] CFG_ISOLATION   = 3'd0;
  localparam logic [2:0] CFG_MUON_SEP    = 3'd1;
  localparam logic [2:0] CFG_POOL_HITS   = 3'd2;
  localparam logic [2:0] CFG_AD_CHARGE   = 3'd3;
  localparam logic [2:0] CFG_PROMPT_LOW  = 3'd4;
  localparam logic [2:0] CFG_DELAYED_LOW = 3'd5;
  localparam logic [2:0] CFG_ENERGY_HIGH = 3'd6;

  localparam logic [2:0] DET_POOL_A = 3'd5;
  localparam logic [2:0] DET_POOL_B = 3'd6;
  localparam logic [2:0] DET_RPC    = 3'd7;

  localparam logic [1:0] HIST_ALL   = 2'd0;
  localparam logic [1:0] HIST_LOOSE = 2'd1;
  localparam logic [1:0] HIST_TIGHT = 2'd2;

  typedef enum logic [2:0] {
    CLS_CROSS    = 3'd0,
    CLS_MUON     = 3'd1,
    CLS_FLASHER  = 3'd2,
    CLS_SINGLE   = 3'd3,
    CLS_OTHER    = 3'd4,
    CLS_READBACK = 3'd5
  } event_class_t;

  typedef enum logic [1:0] {
    JOB_RESULT,
    JOB_READ,
    JOB_MUON,
    JOB_FILL
  } job_kind_t;

  typedef struct packed {
    job_kind_t    kind;
    event_class_t cls;
    logic [62:0]  tm;
    logic [62:0]  prev;
    logic         loose;
    logic         tight;
    logic [1:0]   sel;
    logic [7:0]   bin;
  } job_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_MADDR,
    B_DT,
    B_MUL,
    B_BIN,
    B_INC
  } back_state_t;

  function automatic logic gap_exceeds(input logic [62:0] later, input logic [62:0] earlier,
                                       input logic [15:0] limit_us);
    logic [62:0] diff;
    logic [25:0] lim_ns;
    diff   = later - earlier;
    lim_ns = 26'(limit_us) * 26'(NS_PER_US);
    return (later > earlier) && (diff > 63'(lim_ns));
  endfunction

endpackage

// ----- hw/rtl/mvih_ram.sv -----
module mvih_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/mvih_front.sv -----
module mvih_front #(
  parameter int DETECTOR_COUNT = mvih_pkg::DETECTOR_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                operation,
  input  logic [2:0]                          detector,
  input  logic [31:0]                         trigger_type,
  input  logic [62:0]                         time_ns,
  input  logic [19:0]                         energy_kev,
  input  logic [9:0]                          hit_count,
  input  logic [23:0]                         nominal_charge,
  input  logic                                is_flasher,
  input  logic [1:0]                          hist_select,
  input  logic [7:0]                          hist_bin,
  input  logic                                cfg_write,
  input  logic [mvih_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mvih_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                clearing,
  input  logic                                q_full,
  output logic                                q_push,
  output mvih_pkg::job_t                      q_data
);
  import mvih_pkg::*;

  localparam int DI_W = DETECTOR_COUNT > 1 ? $clog2(DETECTOR_COUNT) : 1;

  logic [15:0] iso_gap_us, muon_gap_us;
  logic [9:0]  pool_hit_threshold;
  logic [23:0] ad_charge_threshold;
  logic [19:0] prompt_low_kev, delayed_low_kev, energy_high_kev;

  logic        held;
  logic        h_op, h_flasher;
  logic [2:0]  h_det;
  logic [31:0] h_trig;
  logic [62:0] h_time;
  logic [19:0] h_energy;
  logic [9:0]  h_hits;
  logic [23:0] h_charge;
  logic [1:0]  h_sel;
  logic [7:0]  h_bin;

  logic        have_muon;
  logic [62:0] newest_muon;
  logic [62:0] last_prompt [DETECTOR_COUNT];
  logic [62:0] last_delayed [DETECTOR_COUNT];
  logic        dly_flag [DETECTOR_COUNT];
  logic        pmp_flag [DETECTOR_COUNT];

  logic [DI_W-1:0] d;
  logic cross_veto, is_muon, record, in_range, delayed, prompt, gap_dly, gap_pmp, fire;

  assign full   = held || clearing;
  assign q_push = held && !q_full;
  assign fire   = q_push && !h_op && !cross_veto;

  always_comb begin
    d          = DI_W'(h_det - 3'd1);
    cross_veto = (h_trig & CROSS_MASK) == CROSS_MASK;
    case (h_det)
      DET_RPC:                is_muon = 1'b0;
      DET_POOL_A, DET_POOL_B: is_muon = h_hits > pool_hit_threshold;
      default:                is_muon = h_charge > ad_charge_threshold;
    endcase
    record   = is_muon && (!have_muon || gap_exceeds(h_time, newest_muon, muon_gap_us));
    in_range = (h_det != 3'd0) && ({1'b0, h_det} <= 4'(DETECTOR_COUNT));
    delayed  = h_energy > delayed_low_kev && h_energy < energy_high_kev;
    prompt   = h_energy > prompt_low_kev && h_energy < energy_high_kev;
    gap_dly  = 1'b0;
    gap_pmp  = 1'b0;
    q_data       = '0;
    q_data.kind  = JOB_RESULT;
    q_data.tm    = h_time;
    q_data.sel   = h_sel;
    q_data.bin   = h_bin;
    if (h_op) begin
      q_data.kind = JOB_READ;
      q_data.cls  = CLS_READBACK;
    end else if (cross_veto) begin
      q_data.cls = CLS_CROSS;
    end else if (record) begin
      q_data.kind = JOB_MUON;
      q_data.cls  = CLS_MUON;
    end else if (h_flasher) begin
      q_data.cls = CLS_FLASHER;
    end else if (!in_range) begin
      q_data.cls = CLS_OTHER;
    end else begin
      q_data.cls = CLS_SINGLE;
      gap_dly = gap_exceeds(h_time, last_delayed[d], iso_gap_us);
      gap_pmp = gap_exceeds(h_time, last_prompt[d], iso_gap_us);
      if (delayed) begin
        q_data.kind  = JOB_FILL;
        q_data.prev  = last_delayed[d];
        q_data.loose = gap_dly && dly_flag[d];
        q_data.tight = gap_dly && pmp_flag[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held                <= 1'b0;
      have_muon           <= 1'b0;
      iso_gap_us          <= 16'd200;
      muon_gap_us         <= 16'd10;
      pool_hit_threshold  <= 10'd12;
      ad_charge_threshold <= 24'd3000;
      prompt_low_kev      <= 20'd700;
      delayed_low_kev     <= 20'd6000;
      energy_high_kev     <= 20'd12000;
      for (int i = 0; i < DETECTOR_COUNT; i++) begin
        last_prompt[i]  <= '0;
        last_delayed[i] <= '0;
        dly_flag[i]     <= 1'b0;
        pmp_flag[i]     <= 1'b0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ISOLATION:   iso_gap_us          <= cfg_data[15:0];
          CFG_MUON_SEP:    muon_gap_us         <= cfg_data[15:0];
          CFG_POOL_HITS:   pool_hit_threshold  <= cfg_data[9:0];
          CFG_AD_CHARGE:   ad_charge_threshold <= cfg_data;
          CFG_PROMPT_LOW:  prompt_low_kev      <= cfg_data[19:0];
          CFG_DELAYED_LOW: delayed_low_kev     <= cfg_data[19:0];
          CFG_ENERGY_HIGH: energy_high_kev     <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        held <= 1'b1;
      end else if (q_push) begin
        held <= 1'b0;
      end
      if (fire) begin
        if (record) begin
          have_muon   <= 1'b1;
          newest_muon <= h_time;
        end else if (!h_flasher && in_range) begin
          if (delayed) begin
            last_delayed[d] <= h_time;
            dly_flag[d]     <= gap_dly;
            pmp_flag[d]     <= gap_pmp;
          end
          if (prompt) begin
            last_prompt[d] <= h_time;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      h_op      <= operation;
      h_det     <= detector;
      h_trig    <= trigger_type;
      h_time    <= time_ns;
      h_energy  <= energy_kev;
      h_hits    <= hit_count;
      h_charge  <= nominal_charge;
      h_flasher <= is_flasher;
      h_sel     <= hist_select;
      h_bin     <= hist_bin;
    end
  end

  assert property (@(posedge clk) disable iff (rst) clearing |-> full)
    else $error("item taken during histogram clear");
  assert property (@(posedge clk) disable iff (rst) (push && !full) |=> held)
    else $error("accepted request not held");
  assert property (@(posedge clk) disable iff (rst) (held && q_full) |=> held)
    else $error("held request dropped while queue full");
endmodule

// ----- hw/rtl/mvih_queue.sv -----
module mvih_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  mvih_pkg::job_t wdata,
  output logic           q_full,
  input  logic           rd,
  output logic           q_empty,
  output mvih_pkg::job_t rdata
);
  import mvih_pkg::*;

  localparam int P_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int C_W = $clog2(QUEUE_DEPTH + 1);

  job_t           slots [QUEUE_DEPTH];
  logic [P_W-1:0] wp, rp;
  logic [C_W-1:0] cnt;

  assign q_full  = cnt == C_W'(QUEUE_DEPTH);
  assign q_empty = cnt == '0;
  assign rdata   = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr && !q_full) begin
        wp <= (wp == P_W'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd && !q_empty) begin
        rp <= (rp == P_W'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + C_W'(wr && !q_full) - C_W'(rd && !q_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      slots[wp] <= wdata;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= C_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
                   (wr && !q_full && !(rd && !q_empty)) |=> !q_empty)
    else $error("queue lost a request");
  assert property (@(posedge clk) disable iff (rst) (q_empty == (wp == rp)) || q_full)
    else $error("queue pointers disagree with count");
endmodule

// ----- hw/rtl/mvih_back.sv -----
module mvih_back #(
  parameter int MUON_DEPTH = mvih_pkg::MUON_DEPTH_DEF,
  parameter int HIST_BINS  = mvih_pkg::HIST_BINS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mvih_pkg::job_t q_data,
  output logic           q_pop,
  output logic           clearing,
  input  logic           pop,
  output logic           empty,
  output logic [2:0]     event_class,
  output logic [31:0]    bin_count
);
  import mvih_pkg::*;

  localparam int HIST_SPAN  = HIST_BINS + 2;
  localparam int HIST_DEPTH = 3 * HIST_SPAN;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int BN_W       = $clog2(HIST_SPAN);
  localparam int MA_W       = MUON_DEPTH > 1 ? $clog2(MUON_DEPTH) : 1;
  localparam int CNT_W      = $clog2(MUON_DEPTH + 1);
  localparam logic [63:0] SPAN_NS = 64'(HIST_BINS) * 64'(BIN_NS);

  back_state_t state, state_next;
  job_t        job;
  logic [1:0]  pass;
  logic [CNT_W-1:0] idx, fill_count;
  logic [MA_W-1:0]  wr_idx;
  logic [HA_W-1:0]  clr_addr, haddr, fill_addr;
  logic             rd_ok, neg, over;
  logic [DT_W-1:0]  dt;
  logic [Q_W-1:0]   qest, q;
  logic [BN_W-1:0]  bin_sel;
  logic [62:0]      tsel;
  logic [63:0]      dt_full;
  logic             out_valid;
  event_class_t     out_cls;
  logic [31:0]      out_count;
  logic             take, last_muon, more_pass;
  logic [1:0]       pass_next;

  logic             hist_we, muon_we;
  logic [HA_W-1:0]  hist_waddr, hist_raddr;
  logic [31:0]      hist_wdata, hist_rdata;
  logic [MA_W-1:0]  muon_raddr;
  logic [62:0]      muon_rdata;

  function automatic logic [HA_W-1:0] base_of(input logic [1:0] s);
    case (s)
      HIST_ALL:   return '0;
      HIST_LOOSE: return HA_W'(HIST_SPAN);
      default:    return HA_W'(2 * HIST_SPAN);
    endcase
  endfunction

  mvih_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  mvih_ram #(.WIDTH(63), .DEPTH(MUON_DEPTH)) u_muon (
    .clk(clk), .we(muon_we), .waddr(wr_idx), .wdata(q_data.tm),
    .raddr(muon_raddr), .rdata(muon_rdata)
  );

  assign clearing    = state == B_CLEAR;
  assign empty       = !out_valid;
  assign event_class = out_cls;
  assign bin_count   = out_count;
  assign take        = (state == B_IDLE) && !q_empty && !out_valid;
  assign q_pop       = take;
  assign last_muon   = (idx + CNT_W'(1)) == fill_count;
  assign more_pass   = ((pass == HIST_ALL) && (job.loose || job.tight))
                    || ((pass == HIST_LOOSE) && job.tight);
  assign pass_next   = (pass == HIST_ALL && job.loose) ? HIST_LOOSE : HIST_TIGHT;
  assign tsel        = (pass == HIST_ALL) ? job.tm : job.prev;
  assign dt_full     = {1'b0, tsel} - {1'b0, muon_rdata};

  always_comb begin
    q       = (32'(qest) * 32'(BIN_NS) > 32'(dt)) ? qest - 1'b1 : qest;
    bin_sel = neg ? '0 : over ? BN_W'(HIST_BINS + 1) : BN_W'(q) + 1'b1;
    fill_addr = base_of(pass) + HA_W'(bin_sel);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_addr == HA_W'(HIST_DEPTH - 1)) state_next = B_IDLE;
      B_IDLE: begin
        if (take) begin
          if (q_data.kind == JOB_READ) state_next = B_READ;
          else if (q_data.kind == JOB_FILL && fill_count != '0) state_next = B_MADDR;
        end
      end
      B_READ:  state_next = B_IDLE;
      B_MADDR: state_next = B_DT;
      B_DT:    state_next = B_MUL;
      B_MUL:   state_next = B_BIN;
      B_BIN:   state_next = B_INC;
      B_INC:   state_next = (last_muon && !more_pass) ? B_IDLE : B_MADDR;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = haddr;
    hist_wdata = '0;
    hist_raddr = fill_addr;
    muon_we    = 1'b0;
    muon_raddr = idx[MA_W-1:0];
    unique case (state)
      B_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_addr;
      end
      B_IDLE: begin
        hist_raddr = base_of(q_data.sel) + HA_W'(q_data.bin);
        muon_we    = take && q_data.kind == JOB_MUON;
      end
      B_INC: begin
        hist_we    = 1'b1;
        hist_wdata = (hist_rdata == '1) ? hist_rdata : hist_rdata + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      wr_idx     <= '0;
      fill_count <= '0;
    end else begin
      state <= state_next;
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        B_CLEAR: clr_addr <= clr_addr + 1'b1;
        B_IDLE: begin
          if (take) begin
            out_cls   <= q_data.cls;
            out_count <= '0;
            if (q_data.kind == JOB_MUON) begin
              wr_idx <= (wr_idx == MA_W'(MUON_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
              if (fill_count != CNT_W'(MUON_DEPTH)) fill_count <= fill_count + 1'b1;
            end
            if (q_data.kind == JOB_RESULT || q_data.kind == JOB_MUON
                || (q_data.kind == JOB_FILL && fill_count == '0)) begin
              out_valid <= 1'b1;
            end
          end
        end
        B_READ: begin
          out_valid <= 1'b1;
          out_count <= rd_ok ? hist_rdata : '0;
        end
        B_INC: if (last_muon && !more_pass) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        job   <= q_data;
        pass  <= HIST_ALL;
        idx   <= '0;
        rd_ok <= (q_data.sel <= HIST_TIGHT) && (32'(q_data.bin) <= 32'(HIST_BINS + 1));
      end
      B_DT: begin
        neg <= tsel < muon_rdata;
        over <= dt_full >= SPAN_NS;
        dt   <= dt_full[DT_W-1:0];
      end
      B_MUL: qest <= Q_W'((41'(dt) * 41'(DIV_RECIP)) >> DIV_SHIFT);
      B_BIN: haddr <= fill_addr;
      B_INC: begin
        if (last_muon) begin
          idx  <= '0;
          pass <= pass_next;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) fill_count <= CNT_W'(MUON_DEPTH))
    else $error("muon fill count past depth");
  assert property (@(posedge clk) disable iff (rst)
                   (state != B_IDLE && state != B_CLEAR) |-> !out_valid)
    else $error("job running while a result waits");
  assert property (@(posedge clk) disable iff (rst) (state == B_INC) |-> hist_wdata != '0)
    else $error("bin count wrapped");
  assert property (@(posedge clk) disable iff (rst) (state == B_IDLE) |=> state != B_CLEAR)
    else $error("clear pass restarted");
endmodule

// ----- hw/rtl/muon_veto_isolation_histogrammer.sv -----
// Muon veto and isolation histogrammer.
// Input channel: push/full. A request either processes one trigger event
// (operation 0) or reads one histogram bin (operation 1). Output channel:
// empty/pop; every request yields exactly one result (event_class, bin_count)
// in request order. Config: cfg_write/cfg_index/cfg_data, write only while idle.
// A front stage holds one request while it classifies it, then
// hands a job through a 2-entry queue to the back stage, which owns the muon
// ring and the histogram RAM.
// A delayed event walks every stored muon once per histogram it fills, each
// muon in order through RAM read, subtract, reciprocal multiply, bin address
// and read-modify-write; the back stage takes no new job until the walk ends.
// Full stays high while the front holds a request, so the front takes no new
// request until it has handed the held one to the queue.
// Reset: the histogram RAM, all 3 * (HIST_BINS + 2) words, is swept to zero
// with full held high; config registers take their defaults.
// When pop is held low the result waits in the output register; the front and
// queue keep taking up to three more requests before full stays high.
module muon_veto_isolation_histogrammer #(
  parameter int MUON_DEPTH     = mvih_pkg::MUON_DEPTH_DEF,
  parameter int HIST_BINS      = mvih_pkg::HIST_BINS_DEF,
  parameter int DETECTOR_COUNT = mvih_pkg::DETECTOR_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            operation,
  input  logic [2:0]                      detector,
  input  logic [31:0]                     trigger_type,
  input  logic [62:0]                     time_ns,
  input  logic [19:0]                     energy_kev,
  input  logic [9:0]                      hit_count,
  input  logic [23:0]                     nominal_charge,
  input  logic                            is_flasher,
  input  logic [1:0]                      hist_select,
  input  logic [7:0]                      hist_bin,
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      event_class,
  output logic [31:0]                     bin_count,
  input  logic                            cfg_write,
  input  logic [mvih_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvih_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mvih_pkg::*;

  job_t fq_wdata, fq_rdata;
  logic fq_push, fq_full, fq_pop, fq_empty, clearing;

  mvih_front #(.DETECTOR_COUNT(DETECTOR_COUNT)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .operation(operation), .detector(detector), .trigger_type(trigger_type),
    .time_ns(time_ns), .energy_kev(energy_kev), .hit_count(hit_count),
    .nominal_charge(nominal_charge), .is_flasher(is_flasher),
    .hist_select(hist_select), .hist_bin(hist_bin),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .clearing(clearing), .q_full(fq_full), .q_push(fq_push), .q_data(fq_wdata)
  );

  mvih_queue u_queue (
    .clk(clk), .rst(rst), .wr(fq_push), .wdata(fq_wdata), .q_full(fq_full),
    .rd(fq_pop), .q_empty(fq_empty), .rdata(fq_rdata)
  );

  mvih_back #(.MUON_DEPTH(MUON_DEPTH), .HIST_BINS(HIST_BINS)) u_back (
    .clk(clk), .rst(rst), .q_empty(fq_empty), .q_data(fq_rdata), .q_pop(fq_pop),
    .clearing(clearing), .pop(pop), .empty(empty),
    .event_class(event_class), .bin_count(bin_count)
  );
endmodule

// ----- bench/tb_muon_veto_isolation_histogrammer.sv -----
`timescale 1ns / 1ps

module tb_muon_veto_isolation_histogrammer;
  import mvih_pkg::*;

  localparam int RING_DEPTH = MUON_DEPTH_DEF;
  localparam int NBINS      = HIST_BINS_DEF;
  localparam int NDET       = DETECTOR_COUNT_DEF;
  localparam bit OP_EVENT   = 1'b0;
  localparam bit OP_READ    = 1'b1;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef struct {
    bit          op;
    logic [2:0]  det;
    logic [31:0] trig;
    logic [62:0] tm;
    logic [19:0] energy;
    logic [9:0]  hits;
    logic [23:0] charge;
    bit          flash;
    logic [1:0]  sel;
    logic [7:0]  bin;
  } request_t;

  typedef struct {
    event_class_t cls;
    logic [31:0]  count;
  } outcome_t;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic operation = 0;
  logic [2:0] detector = 0;
  logic [31:0] trigger_type = 0;
  logic [62:0] time_ns = 0;
  logic [19:0] energy_kev = 0;
  logic [9:0] hit_count = 0;
  logic [23:0] nominal_charge = 0;
  logic is_flasher = 0;
  logic [1:0] hist_select = 0;
  logic [7:0] hist_bin = 0;
  logic empty;
  logic pop = 0;
  logic [2:0] event_class;
  logic [31:0] bin_count;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;

  muon_veto_isolation_histogrammer u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .detector(detector), .trigger_type(trigger_type), .time_ns(time_ns),
    .energy_kev(energy_kev), .hit_count(hit_count), .nominal_charge(nominal_charge),
    .is_flasher(is_flasher), .hist_select(hist_select), .hist_bin(hist_bin),
    .empty(empty), .pop(pop), .event_class(event_class), .bin_count(bin_count),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("[muon_veto_isolation_histogrammer] ERROR");
    $finish;
  end

  // predictor state
  logic [15:0] iso_us = 200, sep_us = 10;
  logic [9:0]  pool_thr = 12;
  logic [23:0] charge_thr = 3000;
  logic [19:0] prompt_lo = 700, delayed_lo = 6000, energy_hi = 12000;
  logic [62:0] muon_ring [RING_DEPTH];
  int          ring_wr = 0, ring_fill = 0;
  logic [62:0] last_prompt [NDET];
  logic [62:0] last_delayed [NDET];
  bit          dly_iso [NDET];
  bit          pmp_iso [NDET];
  logic [31:0] hist_cnt [3][NBINS+2];

  outcome_t outcome_q[$];
  logic [62:0] tcur = 63'd1_000_000_000;
  int n_sent = 0, n_checked = 0, n_errors = 0, n_cfg = 0;
  int class_seen [6];
  int burst_left = 0;
  bit hold_req = 0;
  int hold_left = 0, rx_mode = 0, rx_left = 0;

  initial begin
    foreach (last_prompt[d]) begin
      last_prompt[d] = 0;
      last_delayed[d] = 0;
      dly_iso[d] = 0;
      pmp_iso[d] = 0;
    end
    foreach (hist_cnt[h, b]) hist_cnt[h][b] = 0;
    foreach (class_seen[c]) class_seen[c] = 0;
  end

  function automatic bit isolated(logic [62:0] later, logic [62:0] earlier, logic [15:0] lim);
    return (later > earlier) && (64'(later - earlier) > 64'(lim) * 64'd1000);
  endfunction

  function automatic int bin_index(logic [62:0] t, logic [62:0] m);
    logic [62:0] d;
    if (t < m) return 0;
    d = t - m;
    if (d >= 63'(NBINS * BIN_NS)) return NBINS + 1;
    return 1 + int'(d / BIN_NS);
  endfunction

  function automatic void fill_muon_hist(int h, logic [62:0] t);
    int b;
    for (int i = 0; i < ring_fill; i++) begin
      b = bin_index(t, muon_ring[i]);
      if (hist_cnt[h][b] != 32'hFFFF_FFFF) hist_cnt[h][b]++;
    end
  endfunction

  function automatic outcome_t classify_event(request_t r);
    outcome_t o;
    bit muon, rec, dly, pmp, gd, gp;
    int d;
    o.count = 0;
    if (r.op == OP_READ) begin
      o.cls = CLS_READBACK;
      if (r.sel <= HIST_TIGHT && r.bin <= NBINS + 1) o.count = hist_cnt[r.sel][r.bin];
      return o;
    end
    if ((r.trig & CROSS_MASK) == CROSS_MASK) begin
      o.cls = CLS_CROSS;
      return o;
    end
    if (r.det == DET_RPC) muon = 0;
    else if (r.det == DET_POOL_A || r.det == DET_POOL_B) muon = r.hits > pool_thr;
    else muon = r.charge > charge_thr;
    if (muon) begin
      rec = (ring_fill == 0) ||
            isolated(r.tm, muon_ring[(ring_wr + RING_DEPTH - 1) % RING_DEPTH], sep_us);
      if (rec) begin
        muon_ring[ring_wr] = r.tm;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (ring_fill < RING_DEPTH) ring_fill++;
        o.cls = CLS_MUON;
        return o;
      end
    end
    if (r.flash) begin
      o.cls = CLS_FLASHER;
      return o;
    end
    if (r.det < 1 || r.det > NDET) begin
      o.cls = CLS_OTHER;
      return o;
    end
    d = r.det - 1;
    dly = r.energy > delayed_lo && r.energy < energy_hi;
    pmp = r.energy > prompt_lo && r.energy < energy_hi;
    if (dly) begin
      fill_muon_hist(HIST_ALL, r.tm);
      gd = isolated(r.tm, last_delayed[d], iso_us);
      gp = isolated(r.tm, last_prompt[d], iso_us);
      if (gd && dly_iso[d]) fill_muon_hist(HIST_LOOSE, last_delayed[d]);
      if (gd && pmp_iso[d]) fill_muon_hist(HIST_TIGHT, last_delayed[d]);
      last_delayed[d] = r.tm;
      dly_iso[d] = gd;
      pmp_iso[d] = gp;
    end
    if (pmp) last_prompt[d] = r.tm;
    o.cls = CLS_SINGLE;
    return o;
  endfunction

  // result side: stall pattern plus a long hold on demand
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      pop <= 0;
      hold_left--;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0: pop <= 1;
        1: pop <= $urandom_range(0, 1);
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && pop && !empty) begin
      if (outcome_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result class=%0d count=%0d",
                                     event_class, bin_count);
      end else begin
        e = outcome_q.pop_front();
        n_checked++;
        if (event_class < 6) class_seen[event_class]++;
        if (event_class !== e.cls || bin_count !== e.count) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch at result %0d: class exp %0d got %0d, count exp %0d got %0d",
                     n_checked, e.cls, event_class, e.count, bin_count);
        end
      end
    end
  end

  task automatic send_request(request_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        push = 0;
      end
    end
    @(negedge clk);
    operation = r.op;
    detector = r.det;
    trigger_type = r.trig;
    time_ns = r.tm;
    energy_kev = r.energy;
    hit_count = r.hits;
    nominal_charge = r.charge;
    is_flasher = r.flash;
    hist_select = r.sel;
    hist_bin = r.bin;
    push = 1;
    do @(posedge clk); while (full);
    outcome_q.push_back(classify_event(r));
    n_sent++;
    burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    push = 0;
    wait (outcome_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      CFG_ISOLATION:   iso_us = val[15:0];
      CFG_MUON_SEP:    sep_us = val[15:0];
      CFG_POOL_HITS:   pool_thr = val[9:0];
      CFG_AD_CHARGE:   charge_thr = val;
      CFG_PROMPT_LOW:  prompt_lo = val[19:0];
      CFG_DELAYED_LOW: delayed_lo = val[19:0];
      CFG_ENERGY_HIGH: energy_hi = val[19:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_write = 0;
  endtask

  task automatic apply_settings(logic [23:0] iso, logic [23:0] sep, logic [23:0] pool,
                                logic [23:0] chg, logic [23:0] plo, logic [23:0] dlo,
                                logic [23:0] ehi);
    wait_idle();
    write_register(CFG_ISOLATION, iso);
    write_register(CFG_MUON_SEP, sep);
    write_register(CFG_POOL_HITS, pool);
    write_register(CFG_AD_CHARGE, chg);
    write_register(CFG_PROMPT_LOW, plo);
    write_register(CFG_DELAYED_LOW, dlo);
    write_register(CFG_ENERGY_HIGH, ehi);
  endtask

  function automatic request_t trigger_event(logic [2:0] det, logic [31:0] trig,
                                             int adv, logic [19:0] e, logic [9:0] hits,
                                             logic [23:0] chg, bit flash);
    request_t r;
    tcur += 63'(adv);
    r = '{op: OP_EVENT, det: det, trig: trig, tm: tcur, energy: e, hits: hits,
          charge: chg, flash: flash, sel: 2'($urandom), bin: 8'($urandom)};
    return r;
  endfunction

  function automatic request_t bin_read(logic [1:0] sel, logic [7:0] bin);
    request_t r;
    r = trigger_event(3'($urandom), $urandom, 0, 20'($urandom), 10'($urandom),
                      24'($urandom), 1'($urandom));
    r.op = OP_READ;
    r.sel = sel;
    r.bin = bin;
    return r;
  endfunction

  function automatic logic [19:0] energy_between(logic [19:0] lo, logic [19:0] hi);
    if (hi > lo + 1) return 20'($urandom_range(lo + 1, hi - 1));
    return 20'($urandom_range(0, 20000));
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    logic [2:0] det;
    pick = $urandom_range(0, 99);
    det = 3'($urandom_range(1, NDET));
    if (pick < 15) begin
      if ($urandom_range(0, 2) == 0)
        r = trigger_event($urandom_range(0, 1) ? DET_POOL_A : DET_POOL_B, 0,
                          $urandom_range(0, 40000), 20'($urandom), 10'($urandom_range(0, 1023)),
                          24'($urandom), 0);
      else
        r = trigger_event(det, 0, $urandom_range(0, 40000), 20'($urandom), 0,
                          24'($urandom_range(0, 24'hFFFFFF)), 0);
    end else if (pick < 45) begin
      r = trigger_event(det, 32'($urandom) & ~CROSS_MASK, $urandom_range(0, 500000),
                        energy_between(delayed_lo, energy_hi), 10'($urandom_range(0, 12)),
                        24'($urandom_range(0, 3000)), 0);
    end else if (pick < 60) begin
      r = trigger_event(det, 0, $urandom_range(0, 300000), energy_between(prompt_lo, energy_hi),
                        0, 24'($urandom_range(0, 3000)), 0);
    end else if (pick < 75) begin
      if ($urandom_range(0, 5) == 0) r = bin_read(2'($urandom), 8'($urandom));
      else r = bin_read(2'($urandom_range(0, 2)), 8'($urandom_range(0, NBINS + 1)));
    end else if (pick < 85) begin
      r = trigger_event(3'($urandom), 32'($urandom) & ~CROSS_MASK, $urandom_range(0, 50000),
                        20'($urandom), 10'($urandom), 24'($urandom), 1'($urandom));
    end else if (pick < 90) begin
      r = trigger_event(3'($urandom), 32'($urandom) | CROSS_MASK, $urandom_range(0, 1000),
                        20'($urandom), 10'($urandom), 24'($urandom), 1'($urandom));
    end else begin
      // noise: any time at all, but never a muon that could freeze the ring
      r = trigger_event(DET_RPC, $urandom, 0, 20'($urandom), 10'($urandom), 24'($urandom),
                        1'($urandom));
      r.tm = {$urandom, $urandom};
      if ($urandom_range(0, 1)) r.tm = tcur - 63'($urandom_range(0, 2000000));
    end
    return r;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_request(random_request());
  endtask

  task automatic test_directed();
    send_request(trigger_event(1, CROSS_MASK, 100, 8000, 0, 24'hFFFFFF, 0));
    send_request(trigger_event(1, 32'h1000_0000, 100, 8000, 0, 0, 0));
    send_request(trigger_event(1, 32'h0000_0002, 1000, 0, 0, 24'hFFFFFF, 0));
    send_request(trigger_event(2, 0, 5000, 0, 0, 24'hFFFFFF, 0));
    send_request(trigger_event(DET_POOL_A, 0, 20000, 0, 10'h3FF, 0, 0));
    send_request(trigger_event(DET_POOL_B, 0, 20000, 8000, 12, 0, 0));
    send_request(trigger_event(DET_RPC, 0, 1000, 8000, 10'h3FF, 24'hFFFFFF, 0));
    send_request(trigger_event(1, 0, 1000, 8000, 0, 0, 1));
    send_request(trigger_event(0, 0, 1000, 8000, 0, 0, 0));
    send_request(trigger_event(1, 0, 300000, 8000, 0, 0, 0));
    send_request(trigger_event(1, 0, 300000, 1000, 0, 0, 0));
    send_request(trigger_event(1, 0, 300000, 8000, 0, 0, 0));
    send_request(trigger_event(1, 0, 500000, 11999, 0, 0, 0));
    send_request(trigger_event(3, 0, -100000, 0, 0, 24'hFFFFFF, 0));
    send_request(trigger_event(2, 0, 400000, 8000, 0, 0, 0));
    send_request(trigger_event(2, 0, -1000, 8000, 0, 0, 0));
    send_request(trigger_event(3, 0, 2000, 12000, 0, 0, 0));
    begin
      request_t r;
      r = trigger_event(4, 0, 0, 9000, 0, 0, 0);
      r.tm = '1;
      send_request(r);
    end
    send_request(trigger_event(4, 0, 250000, 9000, 0, 0, 0));
    send_request(trigger_event(DET_RPC, 32'hFFFF_FFFF, 10, 0, 0, 0, 0));
    send_request(bin_read(HIST_ALL, 0));
    send_request(bin_read(HIST_ALL, NBINS + 1));
    send_request(bin_read(HIST_LOOSE, 1));
    send_request(bin_read(HIST_TIGHT, NBINS + 1));
    send_request(bin_read(2'd3, 5));
    send_request(bin_read(HIST_ALL, NBINS + 2));
    send_request(bin_read(HIST_LOOSE, 8'hFF));
  endtask

  task automatic test_config_sweep();
    apply_settings(0, 0, 0, 0, 0, 0, 0);
    run_random(60);
    apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   24'hFFFFFF, 24'hFFFFFF);
    run_random(60);
    repeat (2) begin
      apply_settings($urandom_range(0, 400), $urandom_range(0, 30), $urandom_range(0, 50),
                     $urandom_range(0, 6000), $urandom_range(0, 2000),
                     $urandom_range(3000, 8000), $urandom_range(9000, 20000));
      run_random(80);
    end
    apply_settings(200, 10, 12, 3000, 700, 6000, 12000);
    write_register(CFG_UNUSED, 24'hFFFFFF);
    run_random(60);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = 1;
    run_random(40);
  endtask

  task automatic test_random_mix();
    int n;
    n = 950 - n_sent;
    if (n < 100) n = 100;
    run_random(n);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random_mix();
    wait_idle();
    repeat (30) @(posedge clk);
    $display("%0d requests, %0d results checked, %0d register writes", n_sent, n_checked, n_cfg);
    $display("classes: cross %0d muon %0d flasher %0d single %0d other %0d read %0d",
             class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4],
             class_seen[5]);
    if (n_errors == 0 && outcome_q.size() == 0) begin
      $display("[muon_veto_isolation_histogrammer] OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[muon_veto_isolation_histogrammer] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mvih_pkg.sv
hw/rtl/mvih_ram.sv
hw/rtl/mvih_front.sv
hw/rtl/mvih_queue.sv
hw/rtl/mvih_back.sv
hw/rtl/muon_veto_isolation_histogrammer.sv
bench/tb_muon_veto_isolation_histogrammer.sv
